FILE: src/lmcq_pkg.sv
// ----------------------------------------------------------------------------
// lmcq_pkg
// Shared types, codes and field widths of the LED-matrix canvas command queue.
// ----------------------------------------------------------------------------
package lmcq_pkg;

  // field widths of the command and word channels
  localparam int unsigned CmdW  = 3;
  localparam int unsigned SegW  = 2;
  localparam int unsigned RegW  = 4;
  localparam int unsigned ColW  = 5;
  localparam int unsigned RowW  = 3;
  localparam int unsigned DataW = 8;

  // canvas geometry per chip
  localparam int unsigned ColsPerChip = 8;
  localparam int unsigned ColSelW     = 3;

  // chip register addresses used by the block itself
  localparam logic [RegW-1:0] RegNoop      = 4'd0;
  localparam logic [RegW-1:0] RegIntensity = 4'd10;

  typedef enum logic [CmdW-1:0] {
    CMD_PUSH    = 3'd0,
    CMD_COL_WR  = 3'd1,
    CMD_PIX_SET = 3'd2,
    CMD_PIX_CLR = 3'd3,
    CMD_CLEAR   = 3'd4,
    CMD_UPDATE  = 3'd5,
    CMD_FLUSH   = 3'd6,
    CMD_BRIGHT  = 3'd7
  } cmd_e;

  typedef struct packed {
    cmd_e              command;
    logic [SegW-1:0]   segment;
    logic [RegW-1:0]   reg_addr;
    logic [ColW-1:0]   column_index;
    logic [RowW-1:0]   row_index;
    logic [DataW-1:0]  data_byte;
  } cmd_t;

  typedef struct packed {
    logic [RegW-1:0]   word_reg;
    logic [DataW-1:0]  word_data;
    logic              frame_end;
    logic              overflow;
    logic              last;
  } word_t;

  // datapath operations, one per cycle
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_PUSH_IN,
    OP_COL_WR,
    OP_CANVAS_RD,
    OP_PIX_WR,
    OP_CLEAR,
    OP_SCAN_INIT,
    OP_SCAN_RD,
    OP_SCAN_CMP,
    OP_BRIGHT,
    OP_DRAIN_START,
    OP_DRAIN_RD,
    OP_DRAIN_EMIT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } ctl_t;

  typedef struct packed {
    cmd_e command;
    logic scan_last;
    logic bright_last;
    logic pending;
    logic chip_zero;
    logic out_free;
  } sts_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_PIX_WR,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_BRIGHT,
    ST_DRN_CHK,
    ST_DRN_RD,
    ST_DRN_EMIT
  } ctrl_state_e;

endpackage

FILE: src/lmcq_if.sv
// ----------------------------------------------------------------------------
// lmcq_if
// Valid/ready channel interfaces: command input and display word output.
// ----------------------------------------------------------------------------
interface lmcq_cmd_if import lmcq_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CmdW-1:0]  command;
  logic [SegW-1:0]  segment;
  logic [RegW-1:0]  reg_addr;
  logic [ColW-1:0]  column_index;
  logic [RowW-1:0]  row_index;
  logic [DataW-1:0] data_byte;

  modport source (
    output valid, command, segment, reg_addr, column_index, row_index, data_byte,
    input  ready
  );
  modport sink (
    input  valid, command, segment, reg_addr, column_index, row_index, data_byte,
    output ready
  );
endinterface

interface lmcq_word_if import lmcq_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [RegW-1:0]  word_reg;
  logic [DataW-1:0] word_data;
  logic             frame_end;
  logic             overflow;
  logic             last;

  modport source (
    output valid, word_reg, word_data, frame_end, overflow, last,
    input  ready
  );
  modport sink (
    input  valid, word_reg, word_data, frame_end, overflow, last,
    output ready
  );
endinterface

FILE: src/lmcq_ctrl.sv
// ----------------------------------------------------------------------------
// lmcq_ctrl
// Sequencer: accepts one command, then steps the datapath through it.
// ----------------------------------------------------------------------------
module lmcq_ctrl import lmcq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output ctl_t ctl_o
);

  ctrl_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and datapath operation
  always_comb begin
    state_d    = state_q;
    ctl_o.op   = OP_NONE;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctl_o.op = OP_LOAD;
          state_d  = ST_DECODE;
        end
      end
      ST_DECODE: begin
        unique case (sts_i.command)
          CMD_PUSH: begin
            ctl_o.op = OP_PUSH_IN;
            state_d  = ST_IDLE;
          end
          CMD_COL_WR: begin
            ctl_o.op = OP_COL_WR;
            state_d  = ST_IDLE;
          end
          CMD_PIX_SET, CMD_PIX_CLR: begin
            ctl_o.op = OP_CANVAS_RD;
            state_d  = ST_PIX_WR;
          end
          CMD_CLEAR: begin
            ctl_o.op = OP_CLEAR;
            state_d  = ST_IDLE;
          end
          CMD_UPDATE: begin
            ctl_o.op = OP_SCAN_INIT;
            state_d  = ST_SCAN_RD;
          end
          CMD_FLUSH: begin
            state_d = ST_DRN_CHK;
          end
          CMD_BRIGHT: begin
            ctl_o.op = OP_SCAN_INIT;
            state_d  = ST_BRIGHT;
          end
          default: begin
            state_d = ST_IDLE;
          end
        endcase
      end
      ST_PIX_WR: begin
        ctl_o.op = OP_PIX_WR;
        state_d  = ST_IDLE;
      end
      ST_SCAN_RD: begin
        ctl_o.op = OP_SCAN_RD;
        state_d  = ST_SCAN_CMP;
      end
      ST_SCAN_CMP: begin
        ctl_o.op = OP_SCAN_CMP;
        state_d  = sts_i.scan_last ? ST_DRN_CHK : ST_SCAN_RD;
      end
      ST_BRIGHT: begin
        ctl_o.op = OP_BRIGHT;
        if (sts_i.bright_last) begin
          state_d = ST_DRN_CHK;
        end
      end
      ST_DRN_CHK: begin
        if (sts_i.pending) begin
          ctl_o.op = OP_DRAIN_START;
          state_d  = ST_DRN_RD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_DRN_RD: begin
        ctl_o.op = OP_DRAIN_RD;
        state_d  = ST_DRN_EMIT;
      end
      ST_DRN_EMIT: begin
        if (sts_i.out_free) begin
          ctl_o.op = OP_DRAIN_EMIT;
          state_d  = sts_i.chip_zero ? ST_DRN_CHK : ST_DRN_RD;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: src/lmcq_dp.sv
// ----------------------------------------------------------------------------
// lmcq_dp
// Datapath: canvas and shadow memories, per-chip word queues, output register.
// ----------------------------------------------------------------------------
module lmcq_dp import lmcq_pkg::*; #(
  parameter int unsigned CHIPS       = 4,
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cmd_t  cmd_i,
  input  ctl_t  ctl_i,
  output sts_t  sts_o,
  output word_t word_o,
  output logic  word_valid_o,
  input  logic  word_ready_i
);

  localparam int unsigned SegIW       = (CHIPS > 1) ? $clog2(CHIPS) : 1;
  localparam int unsigned NumCols     = CHIPS * ColsPerChip;
  localparam int unsigned CIW         = SegIW + ColSelW;
  localparam int unsigned CanvasDepth = 2 ** CIW;
  localparam int unsigned PW          = $clog2(QUEUE_DEPTH);
  localparam int unsigned QAW         = SegIW + PW;
  localparam int unsigned QDepth      = 2 ** QAW;
  localparam int unsigned QWordW      = RegW + DataW;

  cmd_t cmd_q;

  logic [DataW-1:0]       canvas_mem [CanvasDepth];
  logic [CanvasDepth-1:0] canvas_vld_q;
  logic [DataW-1:0]       canvas_rd_q;
  logic                   canvas_rd_vld_q;
  logic [DataW-1:0]       shadow_mem [CanvasDepth];
  logic [CanvasDepth-1:0] shadow_vld_q;
  logic [DataW-1:0]       shadow_rd_q;
  logic                   shadow_rd_vld_q;

  logic [CIW-1:0]         x_q;
  logic [SegIW-1:0]       chip_q;
  logic [PW-1:0]          wp_q [CHIPS];
  logic [PW-1:0]          rp_q [CHIPS];
  logic                   ovf_q;
  logic [QWordW-1:0]      q_mem [QDepth];
  logic [QWordW-1:0]      q_rd_q;

  word_t                  word_q;
  logic                   word_valid_q;

  logic                   col_ok, seg_ok;
  logic [CIW-1:0]         col_idx, canvas_raddr;
  logic [DataW-1:0]       canvas_val, shadow_val, pix_mask, pix_val;
  logic                   scan_diff;
  logic                   cv_we;
  logic [DataW-1:0]       cv_wdata;

  logic                   push_en, push_full;
  logic [SegIW-1:0]       push_chip;
  logic [RegW-1:0]        push_reg;
  logic [DataW-1:0]       push_data;
  logic [PW-1:0]          wp_nxt;

  logic [CHIPS-1:0]       pend;
  logic                   pend_cur, chip_zero, others_pend, after_pend, out_free;
  logic [PW-1:0]          rp_nxt;
  word_t                  word_d;

  // range checks and canvas addressing
  assign col_ok  = int'(cmd_q.column_index) < NumCols;
  assign seg_ok  = int'(cmd_q.segment) < CHIPS;
  assign col_idx = CIW'(cmd_q.column_index);
  assign canvas_raddr = (ctl_i.op == OP_CANVAS_RD) ? col_idx : x_q;

  // entries not written since reset, or for the canvas since clear, read as zero
  assign canvas_val = canvas_rd_vld_q ? canvas_rd_q : '0;
  assign shadow_val = shadow_rd_vld_q ? shadow_rd_q : '0;
  assign scan_diff  = canvas_val != shadow_val;

  // pixel read-modify-write
  assign pix_mask = DataW'(1) << cmd_q.row_index;
  assign pix_val  = (cmd_q.command == CMD_PIX_SET) ? (canvas_val | pix_mask)
                                                   : (canvas_val & ~pix_mask);

  // canvas write port
  always_comb begin
    cv_we    = 1'b0;
    cv_wdata = cmd_q.data_byte;
    if (ctl_i.op == OP_COL_WR) begin
      cv_we = col_ok;
    end else if (ctl_i.op == OP_PIX_WR) begin
      cv_we    = col_ok;
      cv_wdata = pix_val;
    end
  end

  // command capture
  always_ff @(posedge clk_i) begin
    if (ctl_i.op == OP_LOAD) begin
      cmd_q <= cmd_i;
    end
  end

  // canvas and shadow memories
  always_ff @(posedge clk_i) begin
    if (cv_we) begin
      canvas_mem[col_idx] <= cv_wdata;
    end
    if (ctl_i.op == OP_CANVAS_RD || ctl_i.op == OP_SCAN_RD) begin
      canvas_rd_q     <= canvas_mem[canvas_raddr];
      canvas_rd_vld_q <= canvas_vld_q[canvas_raddr];
    end
    if (ctl_i.op == OP_SCAN_CMP && scan_diff) begin
      shadow_mem[x_q] <= canvas_val;
    end
    if (ctl_i.op == OP_SCAN_RD) begin
      shadow_rd_q     <= shadow_mem[x_q];
      shadow_rd_vld_q <= shadow_vld_q[x_q];
    end
  end

  // valid bits stand in for zeroing the canvas and shadow
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      canvas_vld_q <= '0;
      shadow_vld_q <= '0;
    end else begin
      if (ctl_i.op == OP_CLEAR) begin
        canvas_vld_q <= '0;
      end else if (cv_we) begin
        canvas_vld_q[col_idx] <= 1'b1;
      end
      if (ctl_i.op == OP_SCAN_CMP && scan_diff) begin
        shadow_vld_q[x_q] <= 1'b1;
      end
    end
  end

  // push source select
  always_comb begin
    push_en   = 1'b0;
    push_chip = SegIW'(cmd_q.segment);
    push_reg  = cmd_q.reg_addr;
    push_data = cmd_q.data_byte;
    case (ctl_i.op)
      OP_PUSH_IN: begin
        push_en = seg_ok;
      end
      OP_SCAN_CMP: begin
        push_en   = scan_diff;
        push_chip = x_q[CIW-1:ColSelW];
        push_reg  = RegW'(x_q[ColSelW-1:0]) + RegW'(1);
        push_data = canvas_val;
      end
      OP_BRIGHT: begin
        push_en   = 1'b1;
        push_chip = x_q[SegIW-1:0];
        push_reg  = RegIntensity;
      end
      default: begin
        push_en = 1'b0;
      end
    endcase
  end

  // ring queue full check, one slot stays empty
  assign wp_nxt    = (wp_q[push_chip] == PW'(QUEUE_DEPTH - 1)) ? '0
                                                                : wp_q[push_chip] + PW'(1);
  assign push_full = wp_nxt == rp_q[push_chip];

  // pending words per chip
  always_comb begin
    for (int c = 0; c < CHIPS; c++) begin
      pend[c] = wp_q[c] != rp_q[c];
    end
  end

  // drain side of the current chip
  assign pend_cur    = pend[chip_q];
  assign chip_zero   = chip_q == '0;
  assign rp_nxt      = (rp_q[chip_q] == PW'(QUEUE_DEPTH - 1)) ? '0
                                                               : rp_q[chip_q] + PW'(1);
  assign others_pend = |(pend & ~(CHIPS'(1) << chip_q));
  assign after_pend  = pend_cur && (wp_q[chip_q] != rp_nxt);
  assign out_free    = !word_valid_q || word_ready_i;

  always_comb begin
    word_d.word_reg  = pend_cur ? q_rd_q[QWordW-1:DataW] : RegNoop;
    word_d.word_data = pend_cur ? q_rd_q[DataW-1:0] : '0;
    word_d.frame_end = chip_zero;
    word_d.overflow  = ovf_q;
    word_d.last      = chip_zero && !(others_pend || after_pend);
  end

  // queue memory
  always_ff @(posedge clk_i) begin
    if (push_en && !push_full) begin
      q_mem[{push_chip, wp_q[push_chip]}] <= {push_reg, push_data};
    end
    if (ctl_i.op == OP_DRAIN_RD) begin
      q_rd_q <= q_mem[{chip_q, rp_q[chip_q]}];
    end
  end

  // pointers, counters and sticky overflow
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CHIPS; c++) begin
        wp_q[c] <= '0;
        rp_q[c] <= '0;
      end
      ovf_q  <= 1'b0;
      x_q    <= '0;
      chip_q <= '0;
    end else begin
      if (push_en) begin
        if (push_full) begin
          ovf_q <= 1'b1;
        end else begin
          wp_q[push_chip] <= wp_nxt;
        end
      end
      if (ctl_i.op == OP_DRAIN_EMIT && pend_cur) begin
        rp_q[chip_q] <= rp_nxt;
      end
      case (ctl_i.op)
        OP_SCAN_INIT:               x_q <= '0;
        OP_SCAN_CMP, OP_BRIGHT:     x_q <= x_q + CIW'(1);
        default:                    x_q <= x_q;
      endcase
      case (ctl_i.op)
        OP_DRAIN_START: chip_q <= SegIW'(CHIPS - 1);
        OP_DRAIN_EMIT:  chip_q <= chip_q - SegIW'(1);
        default:        chip_q <= chip_q;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_valid_q <= 1'b0;
    end else if (ctl_i.op == OP_DRAIN_EMIT) begin
      word_valid_q <= 1'b1;
    end else if (word_ready_i) begin
      word_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.op == OP_DRAIN_EMIT) begin
      word_q <= word_d;
    end
  end

  assign word_o       = word_q;
  assign word_valid_o = word_valid_q;

  // status to the sequencer
  assign sts_o.command     = cmd_q.command;
  assign sts_o.scan_last   = x_q == CIW'(NumCols - 1);
  assign sts_o.bright_last = x_q == CIW'(CHIPS - 1);
  assign sts_o.pending     = |pend;
  assign sts_o.chip_zero   = chip_zero;
  assign sts_o.out_free    = out_free;

endmodule

FILE: src/led_matrix_canvas_command_queue.sv
// ----------------------------------------------------------------------------
// led_matrix_canvas_command_queue
// Canvas, shadow and per-chip word queues for a daisy chain of LED-matrix
// controllers; drains the queues in frames of one word per chip.
// ----------------------------------------------------------------------------
//  channel  dir  handshake      payload
//  cmd_i    in   valid / ready  command, segment, reg_addr, column_index,
//                               row_index, data_byte
//  word_o   out  valid / ready  word_reg, word_data, frame_end, overflow, last
//
//  A command is taken only when the sequencer is idle. Push, column write and
//  clear end right after decode; pixel set/clear reads the canvas, then writes
//  it; update reads and compares every column, brightness queues one intensity
//  word per chip, and both then drain like flush. Each drained frame reads the
//  queue memory and loads the output register once per chip.
//  A stalled output holds the drain; the last word may still wait in the
//  output register while the next command is taken.
// ----------------------------------------------------------------------------
module led_matrix_canvas_command_queue import lmcq_pkg::*; #(
  parameter int unsigned CHIPS       = 4,
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lmcq_cmd_if.sink    cmd_i,
  lmcq_word_if.source word_o
);

  ctl_t  ctl;
  sts_t  sts;
  cmd_t  cmd_in;
  word_t word;
  logic  word_valid;

  // payload into the command struct
  assign cmd_in.command      = cmd_e'(cmd_i.command);
  assign cmd_in.segment      = cmd_i.segment;
  assign cmd_in.reg_addr     = cmd_i.reg_addr;
  assign cmd_in.column_index = cmd_i.column_index;
  assign cmd_in.row_index    = cmd_i.row_index;
  assign cmd_in.data_byte    = cmd_i.data_byte;

  lmcq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (cmd_i.valid),
    .in_ready_o (cmd_i.ready),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  lmcq_dp #(
    .CHIPS       (CHIPS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd_in),
    .ctl_i        (ctl),
    .sts_o        (sts),
    .word_o       (word),
    .word_valid_o (word_valid),
    .word_ready_i (word_o.ready)
  );

  // word channel outputs
  assign word_o.valid     = word_valid;
  assign word_o.word_reg  = word.word_reg;
  assign word_o.word_data = word.word_data;
  assign word_o.frame_end = word.frame_end;
  assign word_o.overflow  = word.overflow;
  assign word_o.last      = word.last;

  // final word of a command always closes a frame
  a_last_on_frame_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    word_o.valid && word_o.last |-> word_o.frame_end)
    else $error("last word outside frame end");

  // new words appear only while a command is in progress
  a_word_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(word_o.valid) |-> !cmd_i.ready)
    else $error("word loaded while idle");

  // overflow flag never falls back once reported
  a_overflow_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    word_o.valid && word_o.overflow |=> !word_o.valid || word_o.overflow)
    else $error("overflow flag cleared");

endmodule
